// ===== hdl/wfpd_pkg.sv =====
`timescale 1ns / 1ps
package wfpd_pkg;

    localparam int DIST_W   = 13;
    localparam int GAIN_W   = 14;
    localparam int SCALE_W  = 16;
    localparam int SPEED_W  = 14;
    localparam int LIMIT_W  = 12;
    localparam int DUTY_W   = 14;
    localparam int DRIVE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ERR_W   = 11;
    localparam int SUM_W   = 13;
    localparam int DERIV_W = 12;
    localparam int ACC_W   = 29;
    localparam int MB_W    = 17;
    localparam int PROD_W  = ACC_W + MB_W;

    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT  = 3'd7;

    localparam logic [GAIN_W-1:0]  RST_KP     = 14'd3200;
    localparam logic [GAIN_W-1:0]  RST_KI     = 14'd205;
    localparam logic [GAIN_W-1:0]  RST_KD     = 14'd2893;
    localparam logic [SCALE_W-1:0] RST_SCALE  = 16'd256;
    localparam logic [SPEED_W-1:0] RST_CRUISE = 14'd8999;
    localparam logic [LIMIT_W-1:0] RST_LIMIT  = 12'd500;
    localparam logic [DIST_W-1:0]  RST_SIDE   = 13'd120;
    localparam logic [DIST_W-1:0]  RST_FRONT  = 13'd100;

    localparam logic [DRIVE_W-1:0] DRV_COAST = 2'd0;
    localparam logic [DRIVE_W-1:0] DRV_FWD   = 2'd1;
    localparam logic [DRIVE_W-1:0] DRV_REV   = 2'd2;
    localparam logic [DRIVE_W-1:0] DRV_BRAKE = 2'd3;

    localparam int LEFT_OFFSET = 9;
    localparam int DEADZONE    = 6;
    localparam int FAR_LIMIT   = 500;

    localparam logic [1:0] MUL_P = 2'd0;
    localparam logic [1:0] MUL_I = 2'd1;
    localparam logic [1:0] MUL_D = 2'd2;
    localparam logic [1:0] MUL_S = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [SCALE_W-1:0] scale;
        logic [SPEED_W-1:0] cruise;
        logic [LIMIT_W-1:0] limit;
        logic [DIST_W-1:0]  side_thr;
        logic [DIST_W-1:0]  front_thr;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic junction;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== hdl/wfpd_if.sv =====
`timescale 1ns / 1ps
interface wfpd_in_if;
    logic                        valid;
    logic                        ready;
    logic [wfpd_pkg::DIST_W-1:0] front_distance;
    logic [wfpd_pkg::DIST_W-1:0] left_distance;
    logic [wfpd_pkg::DIST_W-1:0] right_distance;

    modport source (output valid, front_distance, left_distance, right_distance,
                    input ready);
    modport sink   (input valid, front_distance, left_distance, right_distance,
                    output ready);
endinterface

interface wfpd_out_if;
    logic                         valid;
    logic                         ready;
    logic [wfpd_pkg::DUTY_W-1:0]  left_duty;
    logic [wfpd_pkg::DRIVE_W-1:0] left_drive;
    logic [wfpd_pkg::DUTY_W-1:0]  right_duty;
    logic [wfpd_pkg::DRIVE_W-1:0] right_drive;
    logic                         junction_stop;

    modport source (output valid, left_duty, left_drive, right_duty, right_drive,
                    junction_stop, input ready);
    modport sink   (input valid, left_duty, left_drive, right_duty, right_drive,
                    junction_stop, output ready);
endinterface

interface wfpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wfpd_pkg::CFG_IDX_W-1:0]  index;
    logic [wfpd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/wfpd_cfg_regs.sv =====
`timescale 1ns / 1ps
module wfpd_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    wfpd_cfg_if.sink         cfg,
    output wfpd_pkg::cfg_t   regs
);
    import wfpd_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KP:     regs_next.kp        = cfg.data[GAIN_W-1:0];
                REG_KI:     regs_next.ki        = cfg.data[GAIN_W-1:0];
                REG_KD:     regs_next.kd        = cfg.data[GAIN_W-1:0];
                REG_SCALE:  regs_next.scale     = cfg.data[SCALE_W-1:0];
                REG_CRUISE: regs_next.cruise    = cfg.data[SPEED_W-1:0];
                REG_LIMIT:  regs_next.limit     = cfg.data[LIMIT_W-1:0];
                REG_SIDE:   regs_next.side_thr  = cfg.data[DIST_W-1:0];
                REG_FRONT:  regs_next.front_thr = cfg.data[DIST_W-1:0];
                default:    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.kp        <= RST_KP;
            regs_reg.ki        <= RST_KI;
            regs_reg.kd        <= RST_KD;
            regs_reg.scale     <= RST_SCALE;
            regs_reg.cruise    <= RST_CRUISE;
            regs_reg.limit     <= RST_LIMIT;
            regs_reg.side_thr  <= RST_SIDE;
            regs_reg.front_thr <= RST_FRONT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hdl/wfpd_ctrl.sv =====
`timescale 1ns / 1ps
module wfpd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wfpd_pkg::ctrl_sts_t   sts,
    output wfpd_pkg::ctrl_cmd_t   cmd
);
    import wfpd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_P     = 3'd2;
    localparam logic [2:0] S_I     = 3'd3;
    localparam logic [2:0] S_D     = 3'd4;
    localparam logic [2:0] S_S     = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.capture = in_valid && in_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = sts.junction ? S_WRITE : S_P;
            end
            S_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = S_I;
            end
            S_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
                state_next  = S_D;
            end
            S_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                state_next  = S_S;
            end
            S_S:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_S;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/wfpd_datapath.sv =====
`timescale 1ns / 1ps
module wfpd_datapath #(
    parameter int DUTY_MAX = 9999
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wfpd_pkg::cfg_t        regs,
    input  wfpd_pkg::ctrl_cmd_t   cmd,
    output wfpd_pkg::ctrl_sts_t   sts,
    wfpd_in_if.sink               sample,
    wfpd_out_if.source            command
);
    import wfpd_pkg::*;

    localparam int SPD_W = ACC_W + 2;
    localparam logic signed [SPD_W-1:0] DMAX = SPD_W'(DUTY_MAX);

    logic [DIST_W-1:0] front_reg;
    logic [DIST_W-1:0] left_reg;
    logic [DIST_W-1:0] right_reg;

    logic signed [SUM_W-1:0]   error_sum_reg;
    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DERIV_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      junction_reg;

    logic                 out_valid_reg;
    logic [DUTY_W-1:0]    left_duty_reg;
    logic [DRIVE_W-1:0]   left_drive_reg;
    logic [DUTY_W-1:0]    right_duty_reg;
    logic [DRIVE_W-1:0]   right_drive_reg;
    logic                 junction_out_reg;

    logic signed [DIST_W+1:0] left_s;
    logic signed [DIST_W+1:0] right_s;
    logic signed [DIST_W+1:0] side_s;
    logic signed [DIST_W+1:0] diff;
    logic                     front_wall;
    logic                     left_open;
    logic                     right_open;
    logic                     junction;
    logic                     far;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W:0]    sum_tmp;
    logic signed [SUM_W:0]    lim;
    logic signed [SUM_W-1:0]  sum_clamped;
    logic signed [DERIV_W-1:0] deriv;

    logic signed [ACC_W-1:0]  mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic signed [PROD_W-1:0] prod_adj;
    logic signed [SPD_W-1:0]  corr;
    logic signed [SPD_W-1:0]  left_speed;
    logic signed [SPD_W-1:0]  right_speed;
    logic [DUTY_W-1:0]        left_duty_c;
    logic [DRIVE_W-1:0]       left_drive_c;
    logic [DUTY_W-1:0]        right_duty_c;
    logic [DRIVE_W-1:0]       right_drive_c;

    function automatic logic [DUTY_W+DRIVE_W-1:0] drive_out(logic signed [SPD_W-1:0] speed);
        logic signed [SPD_W-1:0] sat;
        logic signed [SPD_W-1:0] mag;
        logic [DRIVE_W-1:0]      drv;
        sat = speed;
        if (speed > DMAX)
            sat = DMAX;
        else if (speed < -DMAX)
            sat = -DMAX;
        if (sat > 0)
        begin
            drv = DRV_FWD;
            mag = sat;
        end
        else if (sat < 0)
        begin
            drv = DRV_REV;
            mag = -sat;
        end
        else
        begin
            drv = DRV_COAST;
            mag = '0;
        end
        return {mag[DUTY_W-1:0], drv};
    endfunction

    // error, junction and integral update
    always_comb
    begin
        left_s     = $signed({2'b00, left_reg}) - (DIST_W+2)'(LEFT_OFFSET);
        right_s    = $signed({2'b00, right_reg});
        side_s     = $signed({2'b00, regs.side_thr});
        front_wall = front_reg < regs.front_thr;
        left_open  = left_s > side_s;
        right_open = right_s > side_s;
        junction   = front_wall || (left_open != right_open);
        far        = (left_s >= (DIST_W+2)'(FAR_LIMIT)) || (right_s >= (DIST_W+2)'(FAR_LIMIT));
        diff       = left_s - right_s;
        if (far || ((diff <= (DIST_W+2)'(DEADZONE)) && (diff >= -(DIST_W+2)'(DEADZONE))))
            err = '0;
        else
            err = diff[ERR_W-1:0];
        sum_tmp = $signed({error_sum_reg[SUM_W-1], error_sum_reg}) + (SUM_W+1)'(err);
        lim     = $signed({2'b00, regs.limit});
        if (sum_tmp > lim)
            sum_clamped = lim[SUM_W-1:0];
        else if (sum_tmp < -lim)
            sum_clamped = -lim[SUM_W-1:0];
        else
            sum_clamped = sum_tmp[SUM_W-1:0];
        deriv = DERIV_W'(err) - DERIV_W'(last_error_reg);
    end

    // shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_P:
            begin
                mul_a = ACC_W'(err_reg);
                mul_b = $signed({3'b000, regs.kp});
            end
            MUL_I:
            begin
                mul_a = ACC_W'(error_sum_reg);
                mul_b = $signed({3'b000, regs.ki});
            end
            MUL_D:
            begin
                mul_a = ACC_W'(deriv_reg);
                mul_b = $signed({3'b000, regs.kd});
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = $signed({1'b0, regs.scale});
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // correction, truncated toward zero, and wheel mix
    always_comb
    begin
        prod_adj    = prod_reg[PROD_W-1] ? (prod_reg + PROD_W'(65535)) : prod_reg;
        corr        = SPD_W'(prod_adj >>> 16);
        left_speed  = $signed({{(SPD_W-SPEED_W){1'b0}}, regs.cruise}) - corr;
        right_speed = $signed({{(SPD_W-SPEED_W){1'b0}}, regs.cruise}) + corr;
        {left_duty_c, left_drive_c}   = drive_out(left_speed);
        {right_duty_c, right_drive_c} = drive_out(right_speed);
    end

    assign sts.junction = junction;
    assign sts.out_free = !out_valid_reg || command.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            front_reg <= sample.front_distance;
            left_reg  <= sample.left_distance;
            right_reg <= sample.right_distance;
        end
        if (cmd.load)
        begin
            err_reg      <= err;
            deriv_reg    <= deriv;
            junction_reg <= junction;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_P:   acc_reg  <= mul_p[ACC_W-1:0];
                MUL_S:   prod_reg <= mul_p;
                default: acc_reg  <= acc_reg + mul_p[ACC_W-1:0];
            endcase
        end
        if (cmd.write)
        begin
            if (junction_reg)
            begin
                left_duty_reg   <= '0;
                left_drive_reg  <= DRV_BRAKE;
                right_duty_reg  <= '0;
                right_drive_reg <= DRV_BRAKE;
            end
            else
            begin
                left_duty_reg   <= left_duty_c;
                left_drive_reg  <= left_drive_c;
                right_duty_reg  <= right_duty_c;
                right_drive_reg <= right_drive_c;
            end
            junction_out_reg <= junction_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (junction)
                begin
                    error_sum_reg  <= '0;
                    last_error_reg <= '0;
                end
                else
                begin
                    error_sum_reg  <= sum_clamped;
                    last_error_reg <= err;
                end
            end
            if (cmd.write)
                out_valid_reg <= 1'b1;
            else if (command.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign command.valid         = out_valid_reg;
    assign command.left_duty     = left_duty_reg;
    assign command.left_drive    = left_drive_reg;
    assign command.right_duty    = right_duty_reg;
    assign command.right_drive   = right_drive_reg;
    assign command.junction_stop = junction_out_reg;

endmodule

// ===== hdl/wall_follow_pid_drive.sv =====
`timescale 1ns / 1ps
// A sample is accepted only in idle, then steps through load, the P, I, D and scale
// multiply states and write; a junction goes from load straight to write. The single
// shared multiplier steps through kp, ki, kd and the output scale, so a new sample is
// not taken until the last result is written. A result not yet taken holds the next write.
// Reset (rst_n, async low): registers to defaults, PID state cleared, no result pending.
module wall_follow_pid_drive #(
    parameter int DUTY_MAX = 9999
) (
    input  logic         clk,
    input  logic         rst_n,
    wfpd_cfg_if.sink     cfg,
    wfpd_in_if.sink      sample,
    wfpd_out_if.source   command
);
    import wfpd_pkg::*;

    cfg_t       regs;
    ctrl_cmd_t  cmd;
    ctrl_sts_t  sts;

    wfpd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    wfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wfpd_datapath #(
        .DUTY_MAX (DUTY_MAX)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .cmd     (cmd),
        .sts     (sts),
        .sample  (sample),
        .command (command)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import wfpd_pkg::*;

    localparam int DUTY_LIMIT  = 9999;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 10;

    typedef struct packed {
        logic [DUTY_W-1:0]  left_duty;
        logic [DRIVE_W-1:0] left_drive;
        logic [DUTY_W-1:0]  right_duty;
        logic [DRIVE_W-1:0] right_drive;
        logic               junction_stop;
    } drive_cmd_t;

    logic clk;
    logic rst_n;

    wfpd_cfg_if cfg_ch();
    wfpd_in_if  sample_ch();
    wfpd_out_if command_ch();

    wall_follow_pid_drive #(
        .DUTY_MAX (DUTY_LIMIT)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .sample  (sample_ch),
        .command (command_ch)
    );

    // controller copy: registers and PID state
    cfg_t                      drive_cfg;
    logic signed [SUM_W-1:0]   pid_sum;
    logic signed [ERR_W-1:0]   pid_last;
    drive_cmd_t                expected_cmds[$];

    bit  no_idle;
    int  drift;
    int  mismatches;
    int  samples_sent;
    int  cmds_checked;
    int  junction_cmds;
    int  reg_writes;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d drive commands still owed", $time, expected_cmds.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void speed_to_bridge(input longint speed,
                                            output logic [DUTY_W-1:0] duty,
                                            output logic [DRIVE_W-1:0] drive);
        longint s;
        s = speed;
        if (s > DUTY_LIMIT)
            s = DUTY_LIMIT;
        if (s < -DUTY_LIMIT)
            s = -DUTY_LIMIT;
        if (s > 0)
        begin
            drive = DRV_FWD;
            duty  = s[DUTY_W-1:0];
        end
        else if (s < 0)
        begin
            drive = DRV_REV;
            s     = -s;
            duty  = s[DUTY_W-1:0];
        end
        else
        begin
            drive = DRV_COAST;
            duty  = '0;
        end
    endfunction

    function automatic drive_cmd_t predict_drive(input logic [DIST_W-1:0] f, l, r);
        drive_cmd_t res;
        int     front_v, left_v, right_v, side_v, front_thr_v, lim, err, sum, deriv;
        longint kp_v, ki_v, kd_v, scale_v, cruise_v, raw, corr;
        front_v     = int'(f);
        left_v      = int'(l);
        left_v      = left_v - LEFT_OFFSET;
        right_v     = int'(r);
        side_v      = int'(drive_cfg.side_thr);
        front_thr_v = int'(drive_cfg.front_thr);
        if ((front_v < front_thr_v) || ((left_v > side_v) != (right_v > side_v)))
        begin
            pid_sum  = '0;
            pid_last = '0;
            res.left_duty     = '0;
            res.left_drive    = DRV_BRAKE;
            res.right_duty    = '0;
            res.right_drive   = DRV_BRAKE;
            res.junction_stop = 1'b1;
            return res;
        end
        err = 0;
        if (left_v < FAR_LIMIT && right_v < FAR_LIMIT)
            err = left_v - right_v;
        if (err <= DEADZONE && err >= -DEADZONE)
            err = 0;
        lim = int'(drive_cfg.limit);
        sum = int'(pid_sum);
        sum = sum + err;
        if (sum > lim)
            sum = lim;
        else if (sum < -lim)
            sum = -lim;
        pid_sum = sum[SUM_W-1:0];
        deriv   = err - int'(pid_last);
        pid_last = err[ERR_W-1:0];
        kp_v     = longint'(drive_cfg.kp);
        ki_v     = longint'(drive_cfg.ki);
        kd_v     = longint'(drive_cfg.kd);
        scale_v  = longint'(drive_cfg.scale);
        cruise_v = longint'(drive_cfg.cruise);
        raw  = kp_v * longint'(err) + ki_v * longint'(sum) + kd_v * longint'(deriv);
        corr = (raw * scale_v) / 65536;
        speed_to_bridge(cruise_v - corr, res.left_duty, res.left_drive);
        speed_to_bridge(cruise_v + corr, res.right_duty, res.right_drive);
        res.junction_stop = 1'b0;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [DUTY_W-1:0] want,
                               input logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_cmd
        drive_cmd_t want;
        if (rst_n && command_ch.valid && command_ch.ready)
        begin
            cmds_checked++;
            if (expected_cmds.size() == 0)
            begin
                $display("%0t: drive command with nothing expected, expected none, got %0d/%0d",
                         $time, command_ch.left_duty, command_ch.right_duty);
                mismatches++;
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (want.junction_stop)
                    junction_cmds++;
                check_field("left_duty", want.left_duty, command_ch.left_duty);
                check_field("left_drive", DUTY_W'(want.left_drive),
                            DUTY_W'(command_ch.left_drive));
                check_field("right_duty", want.right_duty, command_ch.right_duty);
                check_field("right_drive", DUTY_W'(want.right_drive),
                            DUTY_W'(command_ch.right_drive));
                check_field("junction_stop", DUTY_W'(want.junction_stop),
                            DUTY_W'(command_ch.junction_stop));
            end
        end
    end

    initial
    begin : cmd_backpressure
        int hold;
        hold = 0;
        command_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                command_ch.ready <= 1'b0;
            end
            else
            begin
                command_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    hold = pick_gap(1'b0);
            end
        end
    end

    task automatic send_sample(input logic [DIST_W-1:0] f, l, r);
        int gap;
        gap = pick_gap(no_idle);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.front_distance <= f;
        sample_ch.left_distance  <= l;
        sample_ch.right_distance <= r;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        expected_cmds.push_back(predict_drive(f, l, r));
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_KP:     drive_cfg.kp        = val[GAIN_W-1:0];
            REG_KI:     drive_cfg.ki        = val[GAIN_W-1:0];
            REG_KD:     drive_cfg.kd        = val[GAIN_W-1:0];
            REG_SCALE:  drive_cfg.scale     = val[SCALE_W-1:0];
            REG_CRUISE: drive_cfg.cruise    = val[SPEED_W-1:0];
            REG_LIMIT:  drive_cfg.limit     = val[LIMIT_W-1:0];
            REG_SIDE:   drive_cfg.side_thr  = val[DIST_W-1:0];
            REG_FRONT:  drive_cfg.front_thr = val[DIST_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        wait_idle();
        write_reg(REG_KP, CFG_DATA_W'(s.kp));
        write_reg(REG_KI, CFG_DATA_W'(s.ki));
        write_reg(REG_KD, CFG_DATA_W'(s.kd));
        write_reg(REG_SCALE, s.scale);
        write_reg(REG_CRUISE, CFG_DATA_W'(s.cruise));
        write_reg(REG_LIMIT, CFG_DATA_W'(s.limit));
        write_reg(REG_SIDE, CFG_DATA_W'(s.side_thr));
        write_reg(REG_FRONT, CFG_DATA_W'(s.front_thr));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic cfg_t default_settings();
        cfg_t s;
        s.kp        = RST_KP;
        s.ki        = RST_KI;
        s.kd        = RST_KD;
        s.scale     = RST_SCALE;
        s.cruise    = RST_CRUISE;
        s.limit     = RST_LIMIT;
        s.side_thr  = RST_SIDE;
        s.front_thr = RST_FRONT;
        return s;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.kp        = GAIN_W'($urandom_range(0, 16383));
        s.ki        = GAIN_W'($urandom_range(0, 16383));
        s.kd        = GAIN_W'($urandom_range(0, 16383));
        s.scale     = SCALE_W'($urandom_range(0, 65535));
        s.cruise    = SPEED_W'($urandom_range(0, DUTY_LIMIT));
        s.limit     = LIMIT_W'($urandom_range(0, 4095));
        s.side_thr  = DIST_W'($urandom_range(0, 600));
        s.front_thr = DIST_W'($urandom_range(0, 300));
        return s;
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // mostly followable corridor samples, some noise that trips junctions
    task automatic send_corridor();
        int s, ft, kind, f, l, r, hi;
        s    = int'(drive_cfg.side_thr);
        ft   = int'(drive_cfg.front_thr);
        kind = $urandom_range(0, 99);
        f    = ($urandom_range(0, 9) == 0) ? ft : $urandom_range(ft, 8191);
        if (kind < 15)
        begin
            f = $urandom_range(0, 8191);
            l = $urandom_range(0, 8191);
            r = $urandom_range(0, 8191);
        end
        else if (kind < 30 && s <= 8181)
        begin
            r = $urandom_range(s + 1, clamp_int(s + 600, 0, 8191));
            l = clamp_int(r + 9 + drift + $urandom_range(0, 40) - 20, s + 10, 8191);
        end
        else
        begin
            hi = (s < FAR_LIMIT - 1 || $urandom_range(0, 9) == 0) ? s : FAR_LIMIT - 1;
            r  = $urandom_range(0, hi);
            l  = clamp_int(r + 9 + drift + $urandom_range(0, 40) - 20, 0,
                           clamp_int(s + 9, 0, 8191));
        end
        send_sample(f[DIST_W-1:0], l[DIST_W-1:0], r[DIST_W-1:0]);
    endtask

    task automatic test_junctions();
        send_sample(13'd0, 13'd500, 13'd500);
        send_sample(13'd8191, 13'd8191, 13'd0);
        send_sample(13'd8191, 13'd0, 13'd8191);
        send_sample(13'd99, 13'd50, 13'd50);
    endtask

    task automatic test_error_shaping();
        send_sample(13'd100, 13'd100, 13'd100);
        send_sample(13'd8191, 13'd115, 13'd100);
        send_sample(13'd8191, 13'd116, 13'd100);
        send_sample(13'd8191, 13'd103, 13'd100);
        send_sample(13'd8191, 13'd102, 13'd100);
        send_sample(13'd8191, 13'd0, 13'd0);
        send_sample(13'd8191, 13'd129, 13'd120);
        send_sample(13'd8191, 13'd130, 13'd121);
        send_sample(13'd8191, 13'd509, 13'd400);
        send_sample(13'd8191, 13'd508, 13'd400);
        send_sample(13'd8191, 13'd8191, 13'd8191);
    endtask

    task automatic test_windup();
        wait_idle();
        write_reg(REG_LIMIT, 16'd30);
        cfg_ch.valid <= 1'b0;
        repeat (4) send_sample(13'd8191, 13'd129, 13'd0);
        repeat (3) send_sample(13'd8191, 13'd9, 13'd120);
    endtask

    task automatic test_speed_range();
        cfg_t s;
        s        = default_settings();
        s.scale  = '0;
        s.cruise = '0;
        apply_settings(s);
        send_sample(13'd8191, 13'd129, 13'd0);
        s.scale = RST_SCALE;
        apply_settings(s);
        send_sample(13'd8191, 13'd129, 13'd0);
        s.kp     = 14'd16383;
        s.ki     = 14'd16383;
        s.kd     = 14'd16383;
        s.scale  = 16'd65535;
        s.cruise = SPEED_W'(DUTY_LIMIT);
        s.limit  = 12'd4095;
        apply_settings(s);
        send_sample(13'd8191, 13'd129, 13'd0);
        send_sample(13'd8191, 13'd9, 13'd120);
        send_sample(13'd8191, 13'd60, 13'd60);
    endtask

    task automatic test_random_phase(input cfg_t s, input int count);
        apply_settings(s);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                drift   = $urandom_range(0, 160) - 80;
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_corridor();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : main
        cfg_t s;
        rst_n    = 1'b0;
        no_idle  = 1'b0;
        drift    = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.front_distance = '0;
        sample_ch.left_distance  = '0;
        sample_ch.right_distance = '0;
        drive_cfg = default_settings();
        pid_sum   = '0;
        pid_last  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_junctions();
        test_error_shaping();
        test_windup();
        test_speed_range();

        test_random_phase(default_settings(), 210);
        test_random_phase(random_settings(), 210);
        s           = random_settings();
        s.kp        = 14'd16383;
        s.ki        = 14'd16383;
        s.kd        = 14'd16383;
        s.scale     = 16'd65535;
        s.cruise    = SPEED_W'(DUTY_LIMIT);
        s.limit     = 12'd4095;
        s.side_thr  = 13'd200;
        s.front_thr = 13'd0;
        test_random_phase(s, 210);
        s           = random_settings();
        s.kp        = '0;
        s.kd        = '0;
        s.cruise    = '0;
        s.limit     = '0;
        s.scale     = SCALE_W'($urandom_range(1, 512));
        s.side_thr  = 13'd8191;
        s.front_thr = 13'd0;
        test_random_phase(s, 210);
        s           = random_settings();
        s.side_thr  = 13'd0;
        s.front_thr = 13'd8191;
        s.limit     = 12'd4095;
        test_random_phase(s, 210);

        wait_idle();
        repeat (20) @(negedge clk);
        $display("tb_top: %0d samples sent, %0d drive commands checked (%0d junction stops)",
                 samples_sent, cmds_checked, junction_cmds);
        $display("tb_top: %0d register writes, defaults plus random and extreme settings",
                 reg_writes);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wfpd_pkg.sv
hdl/wfpd_if.sv
hdl/wfpd_cfg_regs.sv
hdl/wfpd_ctrl.sv
hdl/wfpd_datapath.sv
hdl/wall_follow_pid_drive.sv
dv/tb_top.sv
